@@ design/dtzo_pkg.sv @@
// Shared types, constants and calendar helpers for the time-zone offset unit.
// No dependencies; every other file of the unit imports this package.
package dtzo_pkg;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 6;

  localparam logic [CFG_INDEX_W-1:0] CFG_TZ_WEST    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TZ_HOURS   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TZ_MINUTES = 2'd2;

  localparam logic signed [12:0] DAY_MIN     = 13'sd1440;
  localparam logic signed [12:0] TWO_DAY_MIN = 13'sd2880;

  localparam logic [14:0] YEAR_LOW  = 15'd1400;
  localparam logic [14:0] YEAR_HIGH = 15'd9999;

  // Reciprocal of 60 scaled by 2^16; exact for minute counts below one day.
  localparam logic [10:0] RECIP_60 = 11'd1093;
  // Multiplicative inverse of 25 modulo 2^16 and the divisibility bound.
  localparam logic [15:0] INV_25   = 16'd23593;
  localparam logic [15:0] DIV25_LIM = 16'd2621;

  typedef struct packed {
    logic [13:0] in_year;
    logic [3:0]  in_month;
    logic [4:0]  in_day;
    logic [4:0]  in_hour;
    logic [5:0]  in_minute;
  } in_item_t;

  typedef struct packed {
    logic [13:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [4:0]  out_hour;
    logic [5:0]  out_minute;
    logic        out_error;
  } out_item_t;

  typedef struct packed {
    logic       west;
    logic [4:0] hours;
    logic [5:0] minutes;
  } cfg_t;

  typedef struct packed {
    logic [14:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } date_t;

  typedef struct packed {
    date_t             date;
    logic              leap;
    logic signed [2:0] delta;
    logic [10:0]       tod;
  } mid_t;

  function automatic logic is_leap(logic [13:0] year);
    logic [15:0] prod;
    logic        div25;
    prod  = 16'({2'b00, year} * INV_25);
    div25 = (prod <= DIV25_LIM);
    return (year[1:0] == 2'd0) && (!div25 || (year[3:0] == 4'd0));
  endfunction

  function automatic logic [4:0] month_days(logic [3:0] month, logic leap);
    logic [4:0] days;
    case (month) inside
      4'd4, 4'd6, 4'd9, 4'd11: days = 5'd30;
      4'd2:                    days = leap ? 5'd29 : 5'd28;
      default:                 days = 5'd31;
    endcase
    return days;
  endfunction

  function automatic date_t date_next(date_t dt, logic leap);
    date_t r;
    r = dt;
    if (dt.day < month_days(dt.month, leap)) begin
      r.day = dt.day + 5'd1;
    end else begin
      r.day = 5'd1;
      if (dt.month < 4'd12) begin
        r.month = dt.month + 4'd1;
      end else begin
        r.month = 4'd1;
        r.year  = dt.year + 15'd1;
      end
    end
    return r;
  endfunction

  function automatic date_t date_prev(date_t dt, logic leap);
    date_t r;
    r = dt;
    if (dt.day > 5'd1) begin
      r.day = dt.day - 5'd1;
    end else begin
      if (dt.month > 4'd1) begin
        r.month = dt.month - 4'd1;
      end else begin
        r.month = 4'd12;
        r.year  = dt.year - 15'd1;
      end
      r.day = month_days(r.month, leap);
    end
    return r;
  endfunction

endpackage

@@ design/dtzo_prep.sv @@
// First work stage: clamps the date, adds the offset to the time of day and
// splits the sum into a day change and minutes of day. Depends on dtzo_pkg.
module dtzo_prep (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  dtzo_pkg::in_item_t item,
  input  dtzo_pkg::cfg_t  cfg,
  output logic            mid_valid,
  output dtzo_pkg::mid_t  mid
);
  import dtzo_pkg::*;

  logic [3:0]         month_c;
  logic               leap;
  logic [4:0]         dim;
  logic [4:0]         day_c;
  logic [12:0]        tod_u;
  logic [12:0]        off_u;
  logic signed [12:0] sum;
  logic signed [12:0] norm;
  logic signed [2:0]  delta;
  mid_t               mid_next;

  always_comb begin
    if (item.in_month == 4'd0) begin
      month_c = 4'd1;
    end else if (item.in_month > 4'd12) begin
      month_c = 4'd12;
    end else begin
      month_c = item.in_month;
    end
    leap = is_leap(item.in_year);
    dim  = month_days(month_c, leap);
    if (item.in_day == 5'd0) begin
      day_c = 5'd1;
    end else if (item.in_day > dim) begin
      day_c = dim;
    end else begin
      day_c = item.in_day;
    end
  end

  assign tod_u = ({2'b00, item.in_hour, 6'b0} - {6'b0, item.in_hour, 2'b00})
               + {7'b0, item.in_minute};
  assign off_u = ({2'b00, cfg.hours, 6'b0} - {6'b0, cfg.hours, 2'b00})
               + {7'b0, cfg.minutes};
  assign sum   = cfg.west ? $signed(tod_u) - $signed(off_u)
                          : $signed(tod_u) + $signed(off_u);

  always_comb begin
    if (sum < -DAY_MIN) begin
      norm  = sum + TWO_DAY_MIN;
      delta = -3'sd2;
    end else if (sum < 13'sd0) begin
      norm  = sum + DAY_MIN;
      delta = -3'sd1;
    end else if (sum >= TWO_DAY_MIN) begin
      norm  = sum - TWO_DAY_MIN;
      delta = 3'sd2;
    end else if (sum >= DAY_MIN) begin
      norm  = sum - DAY_MIN;
      delta = 3'sd1;
    end else begin
      norm  = sum;
      delta = 3'sd0;
    end
  end

  always_comb begin
    mid_next.date.year  = {1'b0, item.in_year};
    mid_next.date.month = month_c;
    mid_next.date.day   = day_c;
    mid_next.leap       = leap;
    mid_next.delta      = delta;
    mid_next.tod        = norm[10:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else begin
      mid_valid <= in_valid;
    end
    mid <= mid_next;
  end

endmodule

@@ design/dtzo_adjust.sv @@
// Second work stage: moves the date by up to two days, splits minutes of day
// into hour and minute and checks the year range. Depends on dtzo_pkg.
module dtzo_adjust (
  input  logic              clk,
  input  logic              rst,
  input  logic              mid_valid,
  input  dtzo_pkg::mid_t    mid,
  output logic              done,
  output dtzo_pkg::out_item_t result
);
  import dtzo_pkg::*;

  date_t       d1;
  date_t       d2;
  logic        err;
  logic [21:0] prod;
  logic [4:0]  hour;
  logic [10:0] minute_w;
  out_item_t   result_next;

  always_comb begin
    if (mid.delta > 3'sd0) begin
      d1 = date_next(mid.date, mid.leap);
    end else if (mid.delta < 3'sd0) begin
      d1 = date_prev(mid.date, mid.leap);
    end else begin
      d1 = mid.date;
    end
    if (mid.delta == 3'sd2) begin
      d2 = date_next(d1, mid.leap);
    end else if (mid.delta == -3'sd2) begin
      d2 = date_prev(d1, mid.leap);
    end else begin
      d2 = d1;
    end
  end

  assign err      = (d2.year < YEAR_LOW) || (d2.year > YEAR_HIGH);
  assign prod     = {11'b0, mid.tod} * {11'b0, RECIP_60};
  assign hour     = prod[20:16];
  assign minute_w = mid.tod - ({hour, 6'b0} - {4'b0, hour, 2'b00});

  always_comb begin
    result_next.out_year   = err ? mid.date.year[13:0] : d2.year[13:0];
    result_next.out_month  = err ? mid.date.month : d2.month;
    result_next.out_day    = err ? mid.date.day : d2.day;
    result_next.out_hour   = hour;
    result_next.out_minute = minute_w[5:0];
    result_next.out_error  = err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= mid_valid;
    end
    result <= result_next;
  end

endmodule

@@ design/datetime_timezone_offset_unit.sv @@
// Top level of the time-zone offset unit: input register, offset registers
// and the two work stages. Depends on dtzo_pkg, dtzo_prep and dtzo_adjust.
//
// The unit takes one item on every clock at which start is high; busy stays
// low, so items may follow each other without gaps. Each result is driven on
// the result port once its item has passed the input register, the offset-add
// stage and the date-adjust stage, marked by a one-cycle done pulse; it must
// be captured in that cycle since the receiver cannot stall the unit. Offset
// registers are written through cfg_we, cfg_index and cfg_data and take effect
// for items taken afterwards; write them only while no item is in flight.
module datetime_timezone_offset_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  dtzo_pkg::in_item_t                   item,
  input  logic                                 cfg_we,
  input  logic [dtzo_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [dtzo_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                 done,
  output dtzo_pkg::out_item_t                  result
);
  import dtzo_pkg::*;

  cfg_t     cfg;
  logic     in_valid;
  in_item_t in_reg;
  logic     mid_valid;
  mid_t     mid;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TZ_WEST:    cfg.west    <= cfg_data[0];
        CFG_TZ_HOURS:   cfg.hours   <= cfg_data[4:0];
        CFG_TZ_MINUTES: cfg.minutes <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
    in_reg <= item;
  end

  dtzo_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .item      (in_reg),
    .cfg       (cfg),
    .mid_valid (mid_valid),
    .mid       (mid)
  );

  dtzo_adjust u_adjust (
    .clk       (clk),
    .rst       (rst),
    .mid_valid (mid_valid),
    .mid       (mid),
    .done      (done),
    .result    (result)
  );

  a_done_follows_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 3))
    else $error("result without a matching item");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.out_hour < 5'd24) && (result.out_minute < 6'd60))
    else $error("time of day out of range");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    (done && !result.out_error) |->
      (result.out_year >= 14'd1400) && (result.out_year <= 14'd9999) &&
      (result.out_month >= 4'd1) && (result.out_month <= 4'd12) &&
      (result.out_day >= 5'd1))
    else $error("date out of range without error flag");

  a_error_keeps_year: assert property (@(posedge clk) disable iff (rst)
    (done && result.out_error) |-> (result.out_year == $past(item.in_year, 3)))
    else $error("year changed on error");

endmodule

@@ sim/tb.sv @@
// Testbench for datetime_timezone_offset_unit: shifts dates and times by the
// programmed offset and checks every result against a local calendar predictor.
// Depends on dtzo_pkg and the unit's RTL only.
module tb;
  import dtzo_pkg::*;

  localparam int MIN_PER_HOUR = 60;
  localparam int MIN_PER_DAY  = 1440;
  localparam int FIRST_YEAR   = 1400;
  localparam int LAST_YEAR    = 9999;
  localparam int PIPE_DEPTH   = 3;

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  in_item_t               item;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   done;
  out_item_t              result;

  bit        tz_west_q;
  int        tz_hours_q;
  int        tz_minutes_q;
  out_item_t expected_shifts[$];
  int        mismatches = 0;
  int        idle_pct = 0;

  datetime_timezone_offset_unit uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .done      (done),
    .result    (result)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

  function automatic bit leap_year(int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int days_of_month(int y, int m);
    int len;
    case (m)
      2:           len = leap_year(y) ? 29 : 28;
      4, 6, 9, 11: len = 30;
      default:     len = 31;
    endcase
    return len;
  endfunction

  function automatic out_item_t shift_datetime(in_item_t ts);
    int        yr, mo, dy, tod, off, days, y, m, d;
    out_item_t r;
    yr = ts.in_year;
    mo = ts.in_month;
    dy = ts.in_day;
    if (mo < 1) mo = 1;
    if (mo > 12) mo = 12;
    if (dy < 1) dy = 1;
    if (dy > days_of_month(yr, mo)) dy = days_of_month(yr, mo);
    off = tz_hours_q * MIN_PER_HOUR + tz_minutes_q;
    tod = int'(ts.in_hour) * MIN_PER_HOUR + int'(ts.in_minute);
    tod = tz_west_q ? tod - off : tod + off;
    days = 0;
    while (tod < 0) begin
      tod += MIN_PER_DAY;
      days--;
    end
    while (tod >= MIN_PER_DAY) begin
      tod -= MIN_PER_DAY;
      days++;
    end
    y = yr;
    m = mo;
    d = dy;
    while (days > 0) begin
      if (d < days_of_month(y, m)) begin
        d++;
      end else begin
        d = 1;
        if (m < 12) begin
          m++;
        end else begin
          m = 1;
          y++;
        end
      end
      days--;
    end
    while (days < 0) begin
      if (d > 1) begin
        d--;
      end else begin
        if (m > 1) begin
          m--;
        end else begin
          m = 12;
          y--;
        end
        d = days_of_month(y, m);
      end
      days++;
    end
    r.out_error = (y < FIRST_YEAR) || (y > LAST_YEAR);
    if (r.out_error) begin
      y = yr;
      m = mo;
      d = dy;
    end
    r.out_year   = 14'(y);
    r.out_month  = 4'(m);
    r.out_day    = 5'(d);
    r.out_hour   = 5'(tod / MIN_PER_HOUR);
    r.out_minute = 6'(tod % MIN_PER_HOUR);
    return r;
  endfunction

  function automatic in_item_t make_ts(int y, int mo, int d, int h, int mi);
    in_item_t ts;
    ts.in_year   = 14'(y);
    ts.in_month  = 4'(mo);
    ts.in_day    = 5'(d);
    ts.in_hour   = 5'(h);
    ts.in_minute = 6'(mi);
    return ts;
  endfunction

  function automatic in_item_t random_ts();
    in_item_t ts;
    int       pick, y, mo, len;
    pick = $urandom_range(99);
    if (pick < 12) begin
      ts.in_year   = 14'($urandom);
      ts.in_month  = 4'($urandom);
      ts.in_day    = 5'($urandom);
      ts.in_hour   = 5'($urandom);
      ts.in_minute = 6'($urandom);
    end else begin
      pick = $urandom_range(9);
      if (pick == 0) y = $urandom_range(FIRST_YEAR, FIRST_YEAR + 1);
      else if (pick == 1) y = $urandom_range(LAST_YEAR - 1, LAST_YEAR);
      else y = $urandom_range(FIRST_YEAR, LAST_YEAR);
      mo = $urandom_range(1, 12);
      len = days_of_month(y, mo);
      ts = make_ts(y, mo, $urandom_range(1, len), $urandom_range(0, 23), $urandom_range(0, 59));
      pick = $urandom_range(5);
      if (pick < 2) ts.in_day = 5'(len);
      else if (pick == 2) ts.in_day = 5'd1;
      pick = $urandom_range(3);
      if (pick == 0) ts.in_hour = 5'd23;
      else if (pick == 1) ts.in_hour = 5'd0;
    end
    return ts;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin : check_result
    out_item_t want;
    if (!rst && done) begin
      if (expected_shifts.size() == 0) begin
        report_mismatch("result arrived with no item outstanding");
      end else begin
        want = expected_shifts.pop_front();
        if (result.out_year !== want.out_year)
          report_mismatch($sformatf("out_year %0d, expected %0d", result.out_year,
                                    want.out_year));
        if (result.out_month !== want.out_month)
          report_mismatch($sformatf("out_month %0d, expected %0d", result.out_month,
                                    want.out_month));
        if (result.out_day !== want.out_day)
          report_mismatch($sformatf("out_day %0d, expected %0d", result.out_day,
                                    want.out_day));
        if (result.out_hour !== want.out_hour)
          report_mismatch($sformatf("out_hour %0d, expected %0d", result.out_hour,
                                    want.out_hour));
        if (result.out_minute !== want.out_minute)
          report_mismatch($sformatf("out_minute %0d, expected %0d", result.out_minute,
                                    want.out_minute));
        if (result.out_error !== want.out_error)
          report_mismatch($sformatf("out_error %0d, expected %0d", result.out_error,
                                    want.out_error));
      end
    end
  end

  task automatic send_timestamp(in_item_t ts);
    start <= 1'b1;
    item  <= ts;
    do @(posedge clk); while (busy);
    expected_shifts.push_back(shift_datetime(ts));
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic wait_results();
    start <= 1'b0;
    while (expected_shifts.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  task automatic set_offset(logic [5:0] west_data, logic [5:0] hours_data,
                            logic [5:0] minutes_data);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TZ_WEST;
    cfg_data  <= west_data;
    @(posedge clk);
    cfg_index <= CFG_TZ_HOURS;
    cfg_data  <= hours_data;
    @(posedge clk);
    cfg_index <= CFG_TZ_MINUTES;
    cfg_data  <= minutes_data;
    @(posedge clk);
    cfg_we <= 1'b0;
    tz_west_q    = west_data[0];
    tz_hours_q   = hours_data[4:0];
    tz_minutes_q = minutes_data;
  endtask

  task automatic test_reset_offset();
    send_timestamp(make_ts(2024, 2, 29, 0, 0));
    send_timestamp(make_ts(0, 0, 0, 31, 63));
    send_timestamp(make_ts(16383, 15, 31, 24, 60));
  endtask

  task automatic test_east_shift();
    wait_results();
    set_offset(6'd0, 6'd26, 6'd59);
    send_timestamp(make_ts(9999, 12, 31, 23, 59));
    send_timestamp(make_ts(2000, 2, 28, 22, 0));
    send_timestamp(make_ts(1900, 2, 28, 23, 0));
    send_timestamp(make_ts(2023, 12, 30, 21, 30));
    send_timestamp(make_ts(2024, 4, 30, 23, 59));
    send_timestamp(make_ts(2023, 13, 31, 0, 0));
    send_timestamp(make_ts(2023, 4, 31, 12, 0));
  endtask

  task automatic test_west_shift();
    wait_results();
    set_offset(6'd1, 6'd26, 6'd59);
    send_timestamp(make_ts(1400, 1, 1, 0, 0));
    send_timestamp(make_ts(1400, 1, 3, 3, 0));
    send_timestamp(make_ts(2024, 3, 1, 1, 0));
    send_timestamp(make_ts(2100, 3, 1, 0, 0));
    send_timestamp(make_ts(2023, 1, 1, 0, 58));
    send_timestamp(make_ts(2023, 5, 0, 23, 59));
  endtask

  task automatic test_wide_offset();
    wait_results();
    set_offset(6'd63, 6'd63, 6'd63);
    send_timestamp(make_ts(1400, 1, 2, 0, 0));
    send_timestamp(make_ts(16383, 12, 31, 31, 63));
    wait_results();
    set_offset(6'd62, 6'd31, 6'd63);
    send_timestamp(make_ts(9999, 12, 30, 31, 63));
    send_timestamp(make_ts(2000, 2, 27, 31, 63));
  endtask

  // Offsets that exactly cancel or complete the time of day land on midnight.
  task automatic test_exact_borrow();
    wait_results();
    set_offset(6'd1, 6'd5, 6'd30);
    send_timestamp(make_ts(2020, 1, 1, 5, 30));
    send_timestamp(make_ts(2020, 1, 1, 5, 29));
    wait_results();
    set_offset(6'd0, 6'd18, 6'd30);
    send_timestamp(make_ts(2020, 2, 29, 5, 30));
  endtask

  task automatic test_random_stream();
    int pick;
    for (int blk = 0; blk < 7; blk++) begin
      wait_results();
      pick = $urandom_range(7);
      case (blk)
        0: set_offset(6'd0, 6'd0, 6'd0);
        1: set_offset(6'd0, 6'd26, 6'd59);
        2: set_offset(6'd1, 6'd26, 6'd59);
        default: begin
          if (pick == 0) set_offset(6'($urandom), 6'($urandom), 6'($urandom));
          else set_offset(6'($urandom_range(0, 1)), 6'($urandom_range(0, 26)),
                          6'($urandom_range(0, 59)));
        end
      endcase
      case (blk % 3)
        0: idle_pct = 0;
        1: idle_pct = 62;
        default: idle_pct = 17;
      endcase
      for (int n = 0; n < 100; n++) send_timestamp(random_ts());
    end
  endtask

  initial begin
    rst       <= 1'b1;
    start     <= 1'b0;
    item      <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    tz_west_q    = 1'b0;
    tz_hours_q   = 0;
    tz_minutes_q = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_reset_offset();
    test_east_shift();
    test_west_shift();
    test_wide_offset();
    test_exact_borrow();
    test_random_stream();
    wait_results();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
